/* rtl/fse_pkg.sv */
// fse_pkg: shared constants, types and enums of the edge-replicate fir smoother
// depends on nothing; imported by every module of the block
package fse_pkg;

   localparam int MAX_TAPS       = 31;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int TAP_COUNT_BITS = 5;   // csr field and tap_index field width
   localparam int IDX_BITS       = $clog2(MAX_TAPS);      // tap / window index
   localparam int CNT_BITS       = $clog2(MAX_TAPS + 1);  // counts 0..MAX_TAPS
   localparam int AGE_BITS       = IDX_BITS + 2;          // signed tap age
   localparam int ACC_BITS       = SAMPLE_BITS + COEF_BITS + CNT_BITS + 1;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_COEF   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [IDX_BITS-1:0]         idx;
      logic [COEF_BITS-1:0]        value;
      logic [SAMPLE_BITS-1:0]      sample;
      logic                        line_end;
      logic [CNT_BITS-1:0]         taps;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_DRAIN,
      BK_OUT
   } bk_state_type;

   typedef struct packed {
      logic busy;
      logic pipe_empty;
   } bk_status_type;

endpackage

/* rtl/fse_front.sv */
// fse_front: tap count register, item classification and queue push
// depends on fse_pkg
module fse_front import fse_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TAP_COUNT_BITS-1:0] csr_tap_count,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [TAP_COUNT_BITS-1:0] req_tap_index,
   input  logic [COEF_BITS-1:0]      req_tap_value,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      req_line_end,
   input  logic                      q_full,
   output logic                      q_push,
   output cmd_type                   q_data
);

   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [TAP_COUNT_BITS-1:0] tap_count_in;
   logic [CNT_BITS-1:0]       taps_used;
   logic                      idx_ok;

   assign csr_ready    = 1'b1;
   assign tap_count_in = csr_valid ? csr_tap_count : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_BITS'(1);
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // zero acts as one tap, anything above the kernel size is clamped
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_used = CNT_BITS'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         taps_used = CNT_BITS'(MAX_TAPS);
      end else begin
         taps_used = CNT_BITS'(tap_count_ff);
      end
   end

   assign idx_ok    = (32'(req_tap_index) < MAX_TAPS);
   assign req_ready = !q_full;
   // out-of-range coefficient loads are taken and dropped here
   assign q_push    = req_valid && !q_full && ((req_func == CMD_SAMPLE) || idx_ok);

   always_comb begin
      q_data.kind     = cmd_kind_type'(req_func);
      q_data.idx      = IDX_BITS'(req_tap_index);
      q_data.value    = req_tap_value;
      q_data.sample   = req_sample;
      q_data.line_end = req_line_end;
      q_data.taps     = taps_used;
   end

endmodule

/* rtl/fse_queue.sv */
// fse_queue: short command fifo between front and back
// depends on fse_pkg
module fse_queue import fse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_in;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/fse_back.sv */
// fse_back: sample window, coefficient store, serial mac pipeline and result register
// depends on fse_pkg
module fse_back import fse_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  cmd_type                q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                   rsp_last_of_line,
   output bk_status_type          status
);

   localparam logic [ACC_BITS-1:0] ROUND = ACC_BITS'(1) << (COEF_BITS - 1);

   bk_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]       window_ff [MAX_TAPS];
   logic [COEF_BITS-1:0]         coef_ff   [MAX_TAPS];
   logic [CNT_BITS-1:0]          seen_ff;
   logic [CNT_BITS-1:0]          taps_ff;
   logic [IDX_BITS-1:0]          half_ff;
   logic [IDX_BITS-1:0]          n_ff;
   logic [IDX_BITS-1:0]          d_ff;
   logic                         flush_ff;
   logic [IDX_BITS-1:0]          j_ff;
   logic                         p1_v_ff;
   logic [IDX_BITS-1:0]          a_ff;
   logic [IDX_BITS-1:0]          cj_ff;
   logic                         p2_v_ff;
   logic [SAMPLE_BITS+COEF_BITS-1:0] prod_ff;
   logic [ACC_BITS-1:0]          acc_ff;
   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]       rsp_smoothed_ff;
   logic                         rsp_last_ff;

   logic                         take_sample;
   logic [CNT_BITS-1:0]          seen_next;
   logic [IDX_BITS-1:0]          n_new;
   logic [IDX_BITS-1:0]          half_new;
   logic [IDX_BITS-1:0]          d_new;
   logic                         start_out;
   logic                         issue;
   logic                         last_issue;
   logic                         out_free;
   logic                         load_out;
   logic                         more_out;
   logic signed [AGE_BITS-1:0]   age;
   logic signed [AGE_BITS-1:0]   n_ext;
   logic [IDX_BITS-1:0]          addr;
   logic [ACC_BITS-1:0]          rounded;
   logic [SAMPLE_BITS-1:0]       result;

   // line bookkeeping for an arriving sample
   always_comb begin
      seen_next = (seen_ff == CNT_BITS'(MAX_TAPS)) ? seen_ff : seen_ff + CNT_BITS'(1);
      n_new     = IDX_BITS'(seen_next - CNT_BITS'(1));
      half_new  = IDX_BITS'(q_data.taps >> 1);
      start_out = q_data.line_end || (n_new >= half_new);
      d_new     = (q_data.line_end && (n_new < half_new)) ? n_new : half_new;
   end

   // window age of tap j, clamped to the line's first and last sample
   always_comb begin
      age   = AGE_BITS'(d_ff) + AGE_BITS'(half_ff) - AGE_BITS'(j_ff);
      n_ext = AGE_BITS'(n_ff);
      if (age[AGE_BITS-1]) begin
         addr = '0;
      end else if (age > n_ext) begin
         addr = n_ff;
      end else begin
         addr = IDX_BITS'(age);
      end
   end

   always_comb begin
      rounded = acc_ff + ROUND;
      if (|rounded[ACC_BITS-1:COEF_BITS+SAMPLE_BITS]) begin
         result = '1;
      end else begin
         result = rounded[COEF_BITS+SAMPLE_BITS-1:COEF_BITS];
      end
   end

   // outputs of the sequencer
   always_comb begin
      q_pop       = (state_ff == BK_IDLE) && !q_empty;
      take_sample = q_pop && (q_data.kind == CMD_SAMPLE);
      issue       = (state_ff == BK_MAC);
      last_issue  = issue && ((CNT_BITS'(j_ff) + CNT_BITS'(1)) == taps_ff);
      out_free    = !rsp_valid_ff || rsp_ready;
      load_out    = (state_ff == BK_OUT) && out_free;
      more_out    = flush_ff && (d_ff != '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (take_sample && start_out) begin
               state_in = BK_MAC;
            end
         end
         BK_MAC: begin
            if (last_issue) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = more_out ? BK_MAC : BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         seen_ff      <= '0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_v_ff  <= issue;
         p2_v_ff  <= p1_v_ff;
         if (take_sample) begin
            seen_ff <= q_data.line_end ? '0 : seen_next;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         taps_ff  <= q_data.taps;
         half_ff  <= half_new;
         n_ff     <= n_new;
         d_ff     <= d_new;
         flush_ff <= q_data.line_end;
      end else if (load_out && more_out) begin
         d_ff <= d_ff - IDX_BITS'(1);
      end
      if (take_sample || load_out) begin
         j_ff <= '0;
      end else if (issue) begin
         j_ff <= j_ff + IDX_BITS'(1);
      end
      a_ff    <= addr;
      cj_ff   <= j_ff;
      prod_ff <= window_ff[a_ff] * coef_ff[cj_ff];
      if (take_sample || load_out) begin
         acc_ff <= '0;
      end else if (p2_v_ff) begin
         acc_ff <= acc_ff + ACC_BITS'(prod_ff);
      end
      if (load_out) begin
         rsp_smoothed_ff <= result;
         rsp_last_ff     <= flush_ff && (d_ff == '0);
      end
   end

   // newest sample at index zero
   always_ff @(posedge clock) begin
      if (take_sample) begin
         for (int k = MAX_TAPS - 1; k > 0; k--) begin
            window_ff[k] <= window_ff[k-1];
         end
         window_ff[0] <= q_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_data.kind == CMD_COEF)) begin
         coef_ff[q_data.idx] <= q_data.value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_smoothed      = rsp_smoothed_ff;
   assign rsp_last_of_line  = rsp_last_ff;
   assign status.busy       = (state_ff != BK_IDLE);
   assign status.pipe_empty = !p1_v_ff && !p2_v_ff;

endmodule

/* rtl/fir_smoothing_edge_replicate_top.sv */
// fir_smoothing_edge_replicate_top: streaming symmetric fir smoother with edge replication
// depends on fse_pkg, fse_front, fse_queue, fse_back
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  func, tap_index, tap_value, sample, line_end
// rsp      out        rsp_valid / rsp_ready  smoothed, last_of_line
// csr      in         csr_valid / csr_ready  tap_count
//
// coefficient loads and samples that complete no output leave the queue while the sequencer stays idle
// each output runs one mac per tap on the single 16x16 multiplier, then drains the
// address / multiply / accumulate pipe and loads the result register
// a line_end sample flushes up to half + 1 outputs back to back
// reset is synchronous and active high; tap_count returns to one, coefficients hold junk
// the two-entry queue and the result register let input and output stall independently
module fir_smoothing_edge_replicate_top import fse_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TAP_COUNT_BITS-1:0] csr_tap_count,
   // input items
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [TAP_COUNT_BITS-1:0] req_tap_index,
   input  logic [COEF_BITS-1:0]      req_tap_value,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      req_line_end,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_smoothed,
   output logic                      rsp_last_of_line
);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   cmd_type       q_wr_data;
   cmd_type       q_rd_data;
   bk_status_type bk_status;

   // front: holds tap_count, clamps it per item, drops out-of-range loads
   fse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tap_count (csr_tap_count),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .req_sample    (req_sample),
      .req_line_end  (req_line_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   // command queue decouples intake from the mac sequencer
   fse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   // back: window shift, coefficient writes, serial mac and rounding
   fse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_rd_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_smoothed     (rsp_smoothed),
      .rsp_last_of_line (rsp_last_of_line),
      .status           (bk_status)
   );

`ifndef SYNTH
   // the window may only shift while no product of an older item is in flight
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      !bk_status.busy |-> bk_status.pipe_empty)
      else $error("mac pipe busy while sequencer idle");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   // a result is loaded only after the sequencer left idle for it
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_status.busy))
      else $error("result appeared without mac work");
`endif

endmodule
